/* rtl/level_wind_step_integrator_unit_macros.svh */
// Assertion macros shared by the level-wind integrator RTL.
// Plain text macros only; no dependencies.
`ifndef LEVEL_WIND_STEP_INTEGRATOR_UNIT_MACROS_SVH
`define LEVEL_WIND_STEP_INTEGRATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LWSI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LWSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lwsi_pkg.sv */
// Package for the level-wind step integrator: payload and control types,
// command and register codes, reset values. No dependencies.
package lwsi_pkg;

   // Command codes of an input item
   localparam logic [1:0] CMD_EDGE    = 2'd0;
   localparam logic [1:0] CMD_MESSAGE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACCEL_STEP     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOWER_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_POSITION = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMEOUT_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INDEXING_MODE  = 3'd5;

   localparam int CSR_DATA_WIDTH = 32;

   // Register reset values
   localparam logic        [15:0] RESET_ACCEL_STEP     = 16'd8;
   localparam logic signed [31:0] RESET_UPPER_LIMIT    = 32'sd524284000;
   localparam logic signed [31:0] RESET_LOWER_LIMIT    = -32'sd524288000;
   localparam logic signed [31:0] RESET_START_POSITION = -32'sd573274000;
   localparam logic        [9:0]  RESET_TIMEOUT_LIMIT  = 10'd512;

   typedef struct packed {
      logic [1:0] command;
      logic       edge_direction;
      logic       msg_enable;
   } lwsi_item_type;

   typedef struct packed {
      logic               step_pulse;
      logic               step_direction;
      logic               drive_enabled;
      logic signed [15:0] position_high;
      logic signed [31:0] velocity;
   } lwsi_result_type;

   // start_position is not held here; its write only presets the core
   typedef struct packed {
      logic        [15:0] accel_step;
      logic signed [31:0] upper_limit;
      logic signed [31:0] lower_limit;
      logic        [9:0]  timeout_limit;
      logic               indexing_mode;
   } lwsi_cfg_type;

   // Position preset issued by a start_position write
   typedef struct packed {
      logic               load;
      logic signed [31:0] value;
   } lwsi_preset_type;

endpackage

/* rtl/lwsi_channels.sv */
// Valid/ready channel interfaces for request items and response items.
// Depends on lwsi_pkg.
interface lwsi_req_if import lwsi_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic       edge_direction;
   logic       msg_enable;

   modport source (output valid, output command, output edge_direction,
                   output msg_enable, input ready);
   modport sink (input valid, input command, input edge_direction,
                 input msg_enable, output ready);
endinterface

interface lwsi_rsp_if import lwsi_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               step_pulse;
   logic               step_direction;
   logic               drive_enabled;
   logic signed [15:0] position_high;
   logic signed [31:0] velocity;

   modport source (output valid, output step_pulse, output step_direction,
                   output drive_enabled, output position_high, output velocity,
                   input ready);
   modport sink (input valid, input step_pulse, input step_direction,
                 input drive_enabled, input position_high, input velocity,
                 output ready);
endinterface

/* rtl/lwsi_csr.sv */
// Configuration registers of the level-wind integrator, plus the position
// preset strobe on a start_position write. Depends on lwsi_pkg.
module lwsi_csr import lwsi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output lwsi_cfg_type               cfg,
   output lwsi_preset_type            preset
);

   lwsi_cfg_type cfg_ff;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_step     <= RESET_ACCEL_STEP;
         cfg_ff.upper_limit    <= RESET_UPPER_LIMIT;
         cfg_ff.lower_limit    <= RESET_LOWER_LIMIT;
         cfg_ff.timeout_limit  <= RESET_TIMEOUT_LIMIT;
         cfg_ff.indexing_mode  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ACCEL_STEP:     cfg_ff.accel_step     <= csr_write_data[15:0];
            REG_UPPER_LIMIT:    cfg_ff.upper_limit    <= $signed(csr_write_data[31:0]);
            REG_LOWER_LIMIT:    cfg_ff.lower_limit    <= $signed(csr_write_data[31:0]);
            // only acts through the preset strobe below
            REG_START_POSITION: ;
            REG_TIMEOUT_LIMIT:  cfg_ff.timeout_limit  <= csr_write_data[9:0];
            REG_INDEXING_MODE:  cfg_ff.indexing_mode  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

   // Preset strobe, same edge as the register write
   assign preset.load  = csr_write_enable && (csr_index == REG_START_POSITION);
   assign preset.value = $signed(csr_write_data[31:0]);

endmodule

/* rtl/lwsi_core.sv */
// Integrator state (position, velocity, watchdog, enable) and the single-pass
// update for one item. Depends on lwsi_pkg.
module lwsi_core import lwsi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lwsi_cfg_type    cfg,
   input  lwsi_preset_type preset,
   input  logic            advance,
   input  lwsi_item_type   item,
   output lwsi_result_type result
);

   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] speed_ff, speed_in;
   logic               last_dir_ff, last_dir_in;
   logic [15:0]        last_high_ff, last_high_in;
   logic               enabled_ff, enabled_in;
   logic [9:0]         silence_ff, silence_in;
   logic               pulse;
   logic               pulse_dir;
   logic [10:0]        silence_next;

   // Next state for the item in the input stage
   always_comb begin
      position_in  = position_ff;
      speed_in     = speed_ff;
      last_dir_in  = last_dir_ff;
      last_high_in = last_high_ff;
      enabled_in   = enabled_ff;
      silence_in   = silence_ff;
      pulse        = 1'b0;
      pulse_dir    = 1'b0;
      silence_next = {1'b0, silence_ff} + 11'd1;
      if (advance) begin
         unique case (item.command)
            CMD_EDGE: begin
               if (!cfg.indexing_mode) begin
                  // reversal, then zone acceleration
                  if (item.edge_direction != last_dir_ff) begin
                     last_dir_in = item.edge_direction;
                     speed_in    = -speed_ff;
                  end else if (position_ff >= cfg.upper_limit) begin
                     speed_in = speed_ff - $signed({16'd0, cfg.accel_step});
                  end else if (position_ff <= cfg.lower_limit) begin
                     speed_in = speed_ff + $signed({16'd0, cfg.accel_step});
                  end
                  position_in = position_ff + speed_in;
                  // whole-step crossing issues a pulse while the drive is enabled
                  if (position_in[31:16] != last_high_ff) begin
                     last_high_in = position_in[31:16];
                     if (enabled_ff) begin
                        pulse     = 1'b1;
                        pulse_dir = |speed_in[31:16];
                     end
                  end
               end
            end
            CMD_MESSAGE: begin
               silence_in = 10'd0;
               enabled_in = item.msg_enable;
            end
            CMD_TICK: begin
               // watchdog saturates at its limit and drops the drive
               if (silence_next >= {1'b0, cfg.timeout_limit}) begin
                  silence_in = cfg.timeout_limit;
                  enabled_in = 1'b0;
               end else begin
                  silence_in = silence_next[9:0];
               end
            end
            default: ;
         endcase
      end
   end

   // State registers; a start_position write presets the position
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= RESET_START_POSITION;
         speed_ff     <= '0;
         last_dir_ff  <= 1'b0;
         last_high_ff <= RESET_START_POSITION[31:16];
         enabled_ff   <= 1'b1;
         silence_ff   <= '0;
      end else begin
         speed_ff    <= speed_in;
         last_dir_ff <= last_dir_in;
         enabled_ff  <= enabled_in;
         silence_ff  <= silence_in;
         if (preset.load) begin
            position_ff  <= preset.value;
            last_high_ff <= preset.value[31:16];
         end else begin
            position_ff  <= position_in;
            last_high_ff <= last_high_in;
         end
      end
   end

   assign result.step_pulse     = pulse;
   assign result.step_direction = pulse_dir;
   assign result.drive_enabled  = enabled_in;
   assign result.position_high  = position_in[31:16];
   assign result.velocity       = speed_in;

endmodule

/* rtl/level_wind_step_integrator_unit.sv */
// Level-wind step integrator, top level.
// req_ch carries commands: encoder edge (with its direction), control
// message (with an enable bit) and watchdog tick. rsp_ch returns exactly one
// response per request: step pulse, step direction, drive enable, upper half
// of the position and the velocity after that request.
// A transferred request is captured in the input stage; its response is
// registered in the response register when that stage advances. Throughput:
// one request per cycle while rsp_ch does not stall; the whole update
// is one pass through the compare/add path between the input stage and the response register.
// If rsp_ch stalls, the response register holds and one further request
// waits in the input stage; req_ch.ready drops only when both are full.
// Synchronous reset empties both stages, loads the registers with their
// defaults and the position with the default start position, clears the
// velocity and watchdog and enables the drive.
// csr_* writes take effect at the write edge; a start_position write also
// presets the position. Write only while no request is in flight.
`include "level_wind_step_integrator_unit_macros.svh"

module level_wind_step_integrator_unit import lwsi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   lwsi_req_if.sink                   req_ch,
   lwsi_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   lwsi_cfg_type    cfg;
   lwsi_preset_type preset;
   lwsi_item_type   item_ff;
   lwsi_result_type result;
   lwsi_result_type result_ff;
   logic            in_valid_ff;
   logic            out_valid_ff;
   logic            advance;

   lwsi_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .preset           (preset)
   );

   lwsi_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .preset  (preset),
      .advance (advance),
      .item    (item_ff),
      .result  (result)
   );

   // Input stage moves on when the response register is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.command        <= req_ch.command;
         item_ff.edge_direction <= req_ch.edge_direction;
         item_ff.msg_enable     <= req_ch.msg_enable;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.step_pulse     = result_ff.step_pulse;
   assign rsp_ch.step_direction = result_ff.step_direction;
   assign rsp_ch.drive_enabled  = result_ff.drive_enabled;
   assign rsp_ch.position_high  = result_ff.position_high;
   assign rsp_ch.velocity       = result_ff.velocity;

   // Checks
   `LWSI_ASSERT_SAME(a_pulse_needs_drive, clock, reset, rsp_ch.valid && rsp_ch.step_pulse, rsp_ch.drive_enabled, "step pulse while drive disabled")
   `LWSI_ASSERT_SAME(a_dir_only_on_pulse, clock, reset, rsp_ch.valid && !rsp_ch.step_pulse, !rsp_ch.step_direction, "step direction set without pulse")
   `LWSI_ASSERT_NEXT(a_stage_holds, clock, reset, in_valid_ff && !advance, in_valid_ff, "stalled request lost from input stage")

endmodule
